// File: rtl/core/tdd_pkg.sv
// Shared types and constants of the tile deduplicator.
`timescale 1ns / 1ps
package tdd_pkg;
	// Configuration register indexes.
	localparam logic [1:0] CFG_TILE_W = 2'd0;
	localparam logic [1:0] CFG_TILE_H = 2'd1;
	localparam logic [1:0] CFG_DEDUP  = 2'd2;

	localparam int INDEX_BITS = 10;
	localparam int CFG_DATA_BITS = 4;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		S_IN   = 4'b0001,
		S_SCAN = 4'b0010,
		S_CMP  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;
endpackage

// File: rtl/core/tdd_if.sv
// Handshake interfaces for the pixel input and the tile result output.
`timescale 1ns / 1ps
interface tdd_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_value;
	logic       image_start;
	modport source (output valid, output pixel_value, output image_start, input ready);
	modport sink (input valid, input pixel_value, input image_start, output ready);
endinterface

interface tdd_res_if;
	logic       valid;
	logic       ready;
	logic [9:0] tile_index;
	logic       is_new;
	logic       table_full;
	modport source (output valid, output tile_index, output is_new, output table_full,
		input ready);
	modport sink (input valid, input tile_index, input is_new, input table_full,
		output ready);
endinterface

// File: rtl/core/tdd_cell.sv
// One pixel cell of the current tile chain: holds a pixel and compares it.
`timescale 1ns / 1ps
module tdd_cell #(
	parameter int PB = 8
) (
	input  logic          clk,
	input  logic          shift_en,
	input  logic [PB-1:0] d_in,
	input  logic [PB-1:0] lane,
	input  logic          active,
	output logic [PB-1:0] q,
	output logic          mismatch
);
	logic [PB-1:0] pix_q;

	// Take the pixel on d_in (the neighbour's, or the new pixel at the head) on every accepted beat.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			pix_q <= d_in;
		end
	end

	assign q = pix_q;
	// Only cells inside the current tile size take part in the compare.
	assign mismatch = active && (pix_q != lane);
endmodule

// File: rtl/core/tile_deduplicator.sv
// Top level of the tile deduplicator.
`timescale 1ns / 1ps
// Usage:
// Pixels arrive on the pix channel, one beat per pixel, row-major within each
// tile. A beat with image_start set empties the unique tile table first.
// The current tile sits in a chain of pixel cells; each beat shifts the chain.
// After tile_width*tile_height beats, one result beat leaves on res.
// The stored tiles are read one slot at a time from a wide memory and matched
// against all cells at once; a slot takes a scan state, then a compare state.
// Input is not taken while a tile end is being resolved, nor in a cycle with
// a register write.
// A result waits in an output register; if res stalls while that register is
// still full, the next tile end holds its result and input stays blocked
// until the register frees.
// Reset empties the table and restores tile size 8x8 with dedup on. The
// memory needs no clearing pass. Writing tile_width or tile_height also
// empties the table and restarts the current tile.
module tile_deduplicator #(
	parameter int PIXEL_BITS = 8,
	parameter int MAX_TILE_W = 8,
	parameter int MAX_TILE_H = 8,
	parameter int MAX_TILES  = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [tdd_pkg::CFG_DATA_BITS-1:0] cfg_data,
	tdd_pix_if.sink pix,
	tdd_res_if.source res
);
	import tdd_pkg::*;

	localparam int PB = PIXEL_BITS;
	localparam int SLOT = MAX_TILE_W * MAX_TILE_H;
	localparam int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
	localparam int CW = $clog2(MAX_TILES + 1);
	localparam int PW = $clog2(SLOT + 1);
	localparam int WW = $clog2(MAX_TILE_W + 1);
	localparam int HW = $clog2(MAX_TILE_H + 1);

	logic [3:0] tile_w_q, tile_h_q;
	logic       dedup_q;
	state_t     state_q;
	logic [CW-1:0] ucount_q, slot_q, res_idx_q;
	logic       res_new_q, res_full_q;
	logic [PW-1:0] pos_q;
	logic       out_valid_q, out_new_q, out_full_q;
	logic [INDEX_BITS-1:0] out_idx_q;

	logic [SLOT*PB-1:0] mem [MAX_TILES];
	logic [SLOT*PB-1:0] rd_row_q;
	logic [SLOT*PB-1:0] cells_vec;
	logic [SLOT-1:0]    mism;

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [PW-1:0] count;
	logic [PW-1:0] p_cur;
	logic          acc, match, room;
	logic [PB+7:0] pix_ext;
	logic [PB-1:0] pix_in;
	logic [CW+INDEX_BITS-1:0] idx_ext;

	// Clamp the tile size to 1..maximum and form the pixel count.
	always_comb begin
		if (tile_w_q == 4'd0) w_eff = WW'(1);
		else if ({28'd0, tile_w_q} > MAX_TILE_W) w_eff = WW'(MAX_TILE_W);
		else w_eff = WW'(tile_w_q);
		if (tile_h_q == 4'd0) h_eff = HW'(1);
		else if ({28'd0, tile_h_q} > MAX_TILE_H) h_eff = HW'(MAX_TILE_H);
		else h_eff = HW'(tile_h_q);
	end
	assign count = PW'(w_eff * h_eff);

	assign pix_ext = {{PB{1'b0}}, pix.pixel_value};
	assign pix_in  = pix_ext[PB-1:0];

	// A register write takes the cycle, so no pixel beat is taken with it.
	assign pix.ready = (state_q == S_IN) && !cfg_we;
	assign acc = pix.valid && pix.ready;

	// Position of this beat within the tile.
	always_comb begin
		p_cur = pix.image_start ? '0 : pos_q;
		if (p_cur >= count) p_cur = '0;
	end

	// Chain of pixel cells: new pixel enters cell 0 and the rest move along.
	for (genvar k = 0; k < SLOT; k++) begin : g_cell
		logic [PB-1:0] d;
		if (k == 0) begin : g_head
			assign d = pix_in;
		end else begin : g_body
			assign d = cells_vec[(k-1)*PB +: PB];
		end
		tdd_cell #(.PB(PB)) u_cell (
			.clk      (clk),
			.shift_en (acc),
			.d_in     (d),
			.lane     (rd_row_q[k*PB +: PB]),
			.active   (PW'(k) < count),
			.q        (cells_vec[k*PB +: PB]),
			.mismatch (mism[k])
		);
	end

	assign match = ~|mism;
	assign room  = ucount_q < CW'(MAX_TILES);

	// Stored tile memory: read one slot while scanning, write a new tile.
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN) begin
			rd_row_q <= mem[slot_q[AW-1:0]];
		end
		if (state_q == S_SCAN && !(dedup_q && slot_q < ucount_q) && room) begin
			mem[ucount_q[AW-1:0]] <= cells_vec;
		end
	end

	// Sequencer, configuration registers and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IN;
			tile_w_q    <= 4'd8;
			tile_h_q    <= 4'd8;
			dedup_q     <= 1'b1;
			ucount_q    <= '0;
			pos_q       <= '0;
			slot_q      <= '0;
			res_idx_q   <= '0;
			res_new_q   <= 1'b0;
			res_full_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_new_q   <= 1'b0;
			out_full_q  <= 1'b0;
		end else begin
			// The output register fills from a finished tile and empties on a taken beat.
			if (state_q == S_DONE && (!out_valid_q || res.ready)) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_TILE_W: begin
						tile_w_q <= cfg_data;
						ucount_q <= '0;
						pos_q    <= '0;
					end
					CFG_TILE_H: begin
						tile_h_q <= cfg_data;
						ucount_q <= '0;
						pos_q    <= '0;
					end
					CFG_DEDUP: dedup_q <= cfg_data[0];
					default: ;
				endcase
			end else begin
				unique case (state_q)
					S_IN: begin
						if (acc) begin
							if (pix.image_start) ucount_q <= '0;
							if (p_cur + PW'(1) < count) begin
								pos_q <= p_cur + PW'(1);
							end else begin
								pos_q   <= '0;
								slot_q  <= '0;
								state_q <= S_SCAN;
							end
						end
					end
					S_SCAN: begin
						if (dedup_q && slot_q < ucount_q) begin
							state_q <= S_CMP;
						end else begin
							res_new_q  <= room;
							res_full_q <= !room;
							res_idx_q  <= room ? ucount_q : '0;
							if (room) ucount_q <= ucount_q + CW'(1);
							state_q <= S_DONE;
						end
					end
					S_CMP: begin
						if (match) begin
							res_idx_q  <= slot_q;
							res_new_q  <= 1'b0;
							res_full_q <= 1'b0;
							state_q    <= S_DONE;
						end else begin
							slot_q  <= slot_q + CW'(1);
							state_q <= S_SCAN;
						end
					end
					S_DONE: begin
						if (!out_valid_q || res.ready) begin
							out_idx_q  <= idx_ext[INDEX_BITS-1:0];
							out_new_q  <= res_new_q;
							out_full_q <= res_full_q;
							state_q    <= S_IN;
						end
					end
					default: state_q <= S_IN;
				endcase
			end
		end
	end

	assign idx_ext = {{INDEX_BITS{1'b0}}, res_idx_q};

	assign res.valid      = out_valid_q;
	assign res.tile_index = out_idx_q;
	assign res.is_new     = out_new_q;
	assign res.table_full = out_full_q;
endmodule

// File: bench/tdd_checker.sv
// Watches the tile deduplicator's ports, predicts each tile result and compares it.
`timescale 1ns / 1ps
module tdd_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [tdd_pkg::CFG_DATA_BITS-1:0] cfg_data,
	tdd_pix_if pix,
	tdd_res_if res,
	output int failures,
	output int pending,
	output int n_new,
	output int n_hit,
	output int n_full
);
	import tdd_pkg::*;

	localparam int SLOTS = 1024;
	localparam int SLOT_PIX = 64;

	typedef struct packed {
		logic [INDEX_BITS-1:0] idx;
		logic                  fresh;
		logic                  full;
	} tile_res_t;

	logic [7:0] tile_store [SLOTS][SLOT_PIX];
	logic [7:0] cur_tile [SLOT_PIX];
	int unsigned stored;
	int unsigned pos;
	logic [3:0] width_reg;
	logic [3:0] height_reg;
	logic dedup_on;
	tile_res_t expected_q [$];

	// A size of zero acts as one, anything above eight as eight.
	function automatic int unsigned clamp_dim(logic [3:0] v);
		if (v == 0) return 1;
		if (v > 8) return 8;
		return v;
	endfunction

	function automatic bit slot_equal(int unsigned s, int unsigned n);
		for (int unsigned i = 0; i < n; i++) begin
			if (tile_store[s][i] != cur_tile[i]) return 0;
		end
		return 1;
	endfunction

	task automatic report(string msg);
		failures++;
		if (failures <= 40) begin
			$display("%0t ns: mismatch: %s", $realtime, msg);
		end
	endtask

	// Takes one pixel beat; at the end of a tile, queues the expected result.
	task automatic take_pixel(logic [7:0] pv, logic st);
		int unsigned n;
		bit hit;
		tile_res_t r;
		n = clamp_dim(width_reg) * clamp_dim(height_reg);
		if (st) begin
			stored = 0;
			pos = 0;
		end
		if (pos >= n) pos = 0;
		cur_tile[pos] = pv;
		pos++;
		if (pos < n) return;
		pos = 0;
		hit = 0;
		r = '0;
		if (dedup_on) begin
			for (int unsigned s = 0; s < stored && !hit; s++) begin
				if (slot_equal(s, n)) begin
					hit = 1;
					r.idx = INDEX_BITS'(s);
				end
			end
		end
		if (hit) begin
			n_hit++;
		end else if (stored < SLOTS) begin
			for (int unsigned i = 0; i < n; i++) tile_store[stored][i] = cur_tile[i];
			r.idx = INDEX_BITS'(stored);
			r.fresh = 1;
			stored++;
			n_new++;
		end else begin
			r.full = 1;
			n_full++;
		end
		expected_q.push_back(r);
	endtask

	// Register writes, pixel beats and result beats, all sampled at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		tile_res_t e;
		if (!arst_n) begin
			stored = 0;
			pos = 0;
			width_reg = 4'd8;
			height_reg = 4'd8;
			dedup_on = 1;
			expected_q.delete();
			failures = 0;
			n_new = 0;
			n_hit = 0;
			n_full = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TILE_W: begin
						width_reg = cfg_data;
						stored = 0;
						pos = 0;
					end
					CFG_TILE_H: begin
						height_reg = cfg_data;
						stored = 0;
						pos = 0;
					end
					CFG_DEDUP: begin
						dedup_on = cfg_data[0];
					end
					default: begin
					end
				endcase
			end
			if (pix.valid && pix.ready) take_pixel(pix.pixel_value, pix.image_start);
			if (res.valid && res.ready) begin
				if (expected_q.size() == 0) begin
					report($sformatf("result beat with no tile pending (index %0d)",
						res.tile_index));
				end else begin
					e = expected_q.pop_front();
					if (res.tile_index !== e.idx)
						report($sformatf("tile_index %0d, expected %0d", res.tile_index, e.idx));
					if (res.is_new !== e.fresh)
						report($sformatf("is_new %0b, expected %0b", res.is_new, e.fresh));
					if (res.table_full !== e.full)
						report($sformatf("table_full %0b, expected %0b", res.table_full, e.full));
				end
			end
		end
		pending = expected_q.size();
	end
endmodule

// File: bench/tb_tile_deduplicator.sv
// Stimulus and verdict for the tile deduplicator testbench.
`timescale 1ns / 1ps
module tb_tile_deduplicator;
	import tdd_pkg::*;

	// An index past the end of the register list.
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	int failures, pending, n_new, n_hit, n_full;
	int beats_sent;
	bit jitter;
	logic [7:0] tile_lib [8][64];
	int lib_n;

	tdd_pix_if pix ();
	tdd_res_if res ();

	tile_deduplicator u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pix(pix), .res(res)
	);

	tdd_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pix(pix), .res(res), .failures(failures),
		.pending(pending), .n_new(n_new), .n_hit(n_hit), .n_full(n_full)
	);

	always #2 clk = ~clk;

	// Result side stalls at random while jitter is on.
	always @(negedge clk) begin
		res.ready <= !(jitter && $urandom_range(99) < 24);
	end

	// Sends one pixel beat; valid stays high for a following beat.
	task automatic send(logic [7:0] pv, logic st);
		while (jitter && $urandom_range(99) < 24) begin
			pix.valid <= 0;
			@(negedge clk);
		end
		pix.valid <= 1;
		pix.pixel_value <= pv;
		pix.image_start <= st;
		@(posedge clk);
		while (!pix.ready) @(posedge clk);
		beats_sent++;
		@(negedge clk);
	endtask

	// Stops sending and waits until every tile result has come back.
	task automatic settle();
		pix.valid <= 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [3:0] d);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
	endtask

	task automatic configure(logic [3:0] w, logic [3:0] h, logic d);
		settle();
		cfg_write(CFG_TILE_W, w);
		cfg_write(CFG_TILE_H, h);
		cfg_write(CFG_DEDUP, {3'b000, d});
		cfg_we <= 0;
		@(negedge clk);
	endtask

	task automatic set_dedup(logic d);
		settle();
		cfg_write(CFG_DEDUP, {3'($urandom_range(7)), d});
		cfg_we <= 0;
		@(negedge clk);
	endtask

	// One tile: often a repeat of a recent tile, sometimes with one bit flipped.
	task automatic send_tile(int n);
		logic [7:0] t [64];
		int k;
		if (lib_n > 0 && $urandom_range(99) < 60) begin
			k = $urandom_range(lib_n - 1);
			t = tile_lib[k];
			if ($urandom_range(9) == 0) t[$urandom_range(n - 1)] ^= 8'(1 << $urandom_range(7));
		end else begin
			for (int m = 0; m < 64; m++) t[m] = 8'($urandom_range(255));
			if (lib_n < 8) begin
				tile_lib[lib_n] = t;
				lib_n++;
			end else begin
				tile_lib[$urandom_range(7)] = t;
			end
		end
		for (int m = 0; m < n; m++)
			send(t[m], (m == 0 && $urandom_range(99) < 4) || $urandom_range(199) == 0);
	endtask

	task automatic run_phase(logic [3:0] w, logic [3:0] h, logic d, int items, bit jit);
		int n, sent;
		n = (w == 0 ? 1 : (w > 8 ? 8 : w)) * (h == 0 ? 1 : (h > 8 ? 8 : h));
		configure(w, h, d);
		lib_n = 0;
		jitter = jit;
		sent = 0;
		while (sent < items) begin
			send_tile(n);
			sent += n;
			if ($urandom_range(99) < 3) set_dedup(1'($urandom_range(1)));
		end
	endtask

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		clk = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		pix.valid = 0;
		pix.pixel_value = '0;
		pix.image_start = 0;
		res.ready = 0;
		jitter = 0;
		beats_sent = 0;
		lib_n = 0;
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: zero size acts as one; extremes of the pixel; restarts.
		configure(4'd0, 4'd0, 1);
		send(8'd0, 0);
		send(8'd255, 0);
		send(8'd0, 0);
		send(8'd255, 0);
		send(8'hAA, 0);
		send(8'h55, 0);
		send(8'd0, 1);
		send(8'd0, 0);
		// Image start in the middle of a tile drops the partial tile.
		configure(4'd2, 4'd1, 1);
		send(8'd1, 0);
		send(8'd7, 1);
		send(8'd9, 0);
		send(8'd7, 0);
		send(8'd9, 0);
		// Dedup off stores a duplicate; turned back on, the first copy matches.
		set_dedup(0);
		send(8'd7, 0);
		send(8'd9, 0);
		set_dedup(1);
		send(8'd7, 0);
		send(8'd9, 0);
		// A write beyond the register list changes nothing.
		settle();
		cfg_write(CFG_UNUSED, 4'hF);
		cfg_we <= 0;
		@(negedge clk);
		send(8'd7, 0);
		send(8'd9, 0);

		// Fill the table with dedup off, then hit it full with dedup on.
		configure(4'd1, 4'd1, 0);
		for (int i = 0; i < 1024; i++) send(8'(i % 200), i == 0);
		set_dedup(1);
		send(8'd250, 0);
		send(8'd5, 0);
		send(8'd255, 0);
		send(8'd199, 0);
		send(8'd250, 1);

		// Random phases over several tile sizes, one with no stalls at all.
		run_phase(4'd1, 4'd1, 1, 40, 1);
		run_phase(4'd2, 4'd3, 1, 90, 0);
		run_phase(4'd8, 4'd8, 1, 128, 1);
		run_phase(4'd4, 4'd2, 0, 40, 1);
		run_phase(4'd15, 4'd15, 1, 64, 1);
		run_phase(4'd3, 4'd5, 1, 45, 1);
		run_phase(4'd0, 4'd7, 1, 28, 1);
		settle();
		repeat (50) @(negedge clk);

		$display("Run covered %0d pixel beats over tile sizes 1x1 to 8x8, dedup on and off.",
			beats_sent);
		$display("Tile results: %0d stored new, %0d matched, %0d refused by a full table.",
			n_new, n_hit, n_full);
		if (failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

// File: tile_deduplicator.f
rtl/core/tdd_pkg.sv
rtl/core/tdd_if.sv
rtl/core/tdd_cell.sv
rtl/core/tile_deduplicator.sv
bench/tdd_checker.sv
bench/tb_tile_deduplicator.sv
